// ===== sv/sspcr_pkg.sv =====
// sspcr_pkg: shared types and constants for the SSP/SPI register unit
// command codes, register offsets, id reset values, controller command struct
// no dependencies
package sspcr_pkg;

	localparam int FIFO_DEPTH_DEF = 8;

	localparam int ID_COUNT = 8;
	localparam int ID_IDX_W = 3;
	localparam int ID_W = 8;
	localparam logic [ID_W-1:0] ID_RESET [ID_COUNT] = '{
		8'd34, 8'd16, 8'd4, 8'd0, 8'd13, 8'd240, 8'd5, 8'd177
	};

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_XCHG  = 2'd2;

	localparam logic [11:0] OFF_CR0     = 12'h000;
	localparam logic [11:0] OFF_CR1     = 12'h004;
	localparam logic [11:0] OFF_DR      = 12'h008;
	localparam logic [11:0] OFF_SR      = 12'h00C;
	localparam logic [11:0] OFF_CPSR    = 12'h010;
	localparam logic [11:0] OFF_IMSC    = 12'h014;
	localparam logic [11:0] OFF_RIS     = 12'h018;
	localparam logic [11:0] OFF_MIS     = 12'h01C;
	localparam logic [11:0] OFF_ICR     = 12'h020;
	localparam logic [11:0] OFF_DMACR   = 12'h024;
	localparam logic [11:0] OFF_ID_BASE = 12'hFE0;

	typedef struct packed {
		logic load;
		logic exec;
	} sspcr_cmd_t;

endpackage

// ===== sv/sspcr_ctrl.sv =====
// sspcr_ctrl: item sequencer for the SSP/SPI register unit
// capture, execute, present result; drives sspcr_cmd_t to the datapath
// depends on sspcr_pkg
module sspcr_ctrl
	import sspcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output sspcr_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_RESP;
			ST_RESP: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RESP);
	assign cmd.load  = in_valid && (state_q == ST_IDLE);
	assign cmd.exec  = (state_q == ST_EXEC);

endmodule

// ===== sv/sspcr_datapath.sv =====
// sspcr_datapath: register file, tx/rx fifo memories and result registers
// executes one captured item when the controller asserts exec
// depends on sspcr_pkg
module sspcr_datapath
	import sspcr_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sspcr_cmd_t          cmd,
	input  logic [1:0]          command,
	input  logic [11:0]         offset,
	input  logic [15:0]         write_data,
	input  logic [15:0]         rx_word,
	input  logic                cfg_valid,
	input  logic [ID_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]     cfg_data,
	output logic [15:0]         read_data,
	output logic                access_error,
	output logic                tx_valid,
	output logic [15:0]         tx_word,
	output logic                interrupt_line
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int HALF = FIFO_DEPTH / 2;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
	localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(HALF);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(FIFO_DEPTH);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] c);
		logic [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(c);
		if (s >= SUM_DEPTH) s = s - SUM_DEPTH;
		return s[PTR_W-1:0];
	endfunction

	// captured item
	logic [1:0]  cmd_q;
	logic [11:0] off_q;
	logic [15:0] wdata_q;
	logic [15:0] rword_q;

	// registers
	logic [15:0]     cr0_q, cr0_d;
	logic [3:0]      cr1_q, cr1_d;
	logic [6:0]      cpsr_q, cpsr_d;
	logic [3:0]      imsc_q, imsc_d;
	logic [1:0]      ris_q, ris_d;
	logic [1:0]      dmacr_q, dmacr_d;
	logic [ID_W-1:0] id_q [ID_COUNT];

	// fifos
	logic [CNT_W-1:0] tx_cnt_q, tx_cnt_d, rx_cnt_q, rx_cnt_d;
	logic [PTR_W-1:0] tx_head_q, tx_head_d, rx_head_q, rx_head_d;
	logic [15:0]      tx_mem_q [FIFO_DEPTH];
	logic [15:0]      rx_mem_q [FIFO_DEPTH];
	logic [15:0]      tx_rdata_q, rx_rdata_q;
	logic             tx_we, rx_we;
	logic [PTR_W-1:0] tx_waddr, rx_waddr;
	logic [15:0]      rx_wdata;

	// results
	logic [15:0] rdata_q, rdata_d;
	logic        err_q, err_d;
	logic        txv_q, txv_d;
	logic [15:0] txw_q, txw_d;

	logic [15:0] fmask;
	logic [3:0]  raw;
	logic [15:0] status;
	logic        id_hit;

	assign fmask = 16'hFFFF >> (4'd15 - cr0_q[3:0]);
	assign raw = {tx_cnt_q <= CNT_HALF, rx_cnt_q >= CNT_HALF, ris_q};
	assign status = {11'd0, tx_cnt_q != '0, rx_cnt_q == CNT_FULL, rx_cnt_q != '0,
		tx_cnt_q != CNT_FULL, tx_cnt_q == '0};
	assign id_hit = (off_q >= OFF_ID_BASE) && (off_q[1:0] == 2'b00);
	assign tx_waddr = ptr_add(tx_head_q, tx_cnt_q);
	assign rx_waddr = ptr_add(rx_head_q, rx_cnt_q);
	assign rx_wdata = rword_q & fmask;

	always_comb begin
		cr0_d     = cr0_q;
		cr1_d     = cr1_q;
		cpsr_d    = cpsr_q;
		imsc_d    = imsc_q;
		ris_d     = ris_q;
		dmacr_d   = dmacr_q;
		tx_cnt_d  = tx_cnt_q;
		rx_cnt_d  = rx_cnt_q;
		tx_head_d = tx_head_q;
		rx_head_d = rx_head_q;
		tx_we     = 1'b0;
		rx_we     = 1'b0;
		rdata_d   = '0;
		err_d     = 1'b0;
		txv_d     = 1'b0;
		txw_d     = '0;
		if (cmd.exec) begin
			unique case (cmd_q)
				CMD_WRITE: begin
					unique case (off_q)
						OFF_CR0:   cr0_d = wdata_q;
						OFF_CR1:   cr1_d = wdata_q[3:0];
						OFF_DR: begin
							if (tx_cnt_q == CNT_FULL) begin
								err_d = 1'b1;
							end else begin
								tx_we    = 1'b1;
								tx_cnt_d = tx_cnt_q + 1'b1;
							end
						end
						OFF_CPSR:  cpsr_d = wdata_q[7:1];
						OFF_IMSC:  imsc_d = wdata_q[3:0];
						OFF_ICR:   ris_d = ris_q & ~wdata_q[1:0];
						OFF_DMACR: dmacr_d = wdata_q[1:0];
						default:   err_d = 1'b1;
					endcase
				end
				CMD_READ: begin
					unique case (off_q)
						OFF_CR0:   rdata_d = cr0_q;
						OFF_CR1:   rdata_d = {12'd0, cr1_q};
						OFF_DR: begin
							if (rx_cnt_q == '0) begin
								ris_d[0] = 1'b1;
							end else begin
								rdata_d   = rx_rdata_q & fmask;
								rx_head_d = ptr_inc(rx_head_q);
								rx_cnt_d  = rx_cnt_q - 1'b1;
							end
						end
						OFF_SR:    rdata_d = status;
						OFF_CPSR:  rdata_d = {8'd0, cpsr_q, 1'b0};
						OFF_IMSC:  rdata_d = {12'd0, imsc_q};
						OFF_RIS:   rdata_d = {12'd0, raw};
						OFF_MIS:   rdata_d = {12'd0, raw & imsc_q};
						OFF_DMACR: rdata_d = {14'd0, dmacr_q};
						default: begin
							if (id_hit) rdata_d = {8'd0, id_q[off_q[4:2]]};
						end
					endcase
				end
				CMD_XCHG: begin
					if (tx_cnt_q != '0 && cr1_q[1]) begin
						txv_d     = 1'b1;
						txw_d     = tx_rdata_q;
						tx_head_d = ptr_inc(tx_head_q);
						tx_cnt_d  = tx_cnt_q - 1'b1;
						if (rx_cnt_q == CNT_FULL) begin
							ris_d[0] = 1'b1;
						end else begin
							rx_we    = 1'b1;
							rx_cnt_d = rx_cnt_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= command;
			off_q   <= offset;
			wdata_q <= write_data;
			rword_q <= rx_word;
		end
		if (cmd.exec) begin
			rdata_q <= rdata_d;
			err_q   <= err_d;
			txv_q   <= txv_d;
			txw_q   <= txw_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr0_q     <= '0;
			cr1_q     <= '0;
			cpsr_q    <= '0;
			imsc_q    <= '0;
			ris_q     <= '0;
			dmacr_q   <= '0;
			tx_cnt_q  <= '0;
			rx_cnt_q  <= '0;
			tx_head_q <= '0;
			rx_head_q <= '0;
			id_q      <= ID_RESET;
		end else begin
			cr0_q     <= cr0_d;
			cr1_q     <= cr1_d;
			cpsr_q    <= cpsr_d;
			imsc_q    <= imsc_d;
			ris_q     <= ris_d;
			dmacr_q   <= dmacr_d;
			tx_cnt_q  <= tx_cnt_d;
			rx_cnt_q  <= rx_cnt_d;
			tx_head_q <= tx_head_d;
			rx_head_q <= rx_head_d;
			if (cfg_valid) id_q[cfg_index] <= cfg_data;
		end
	end

	// fifo memories, head word read every cycle
	always_ff @(posedge clk) begin
		if (tx_we) tx_mem_q[tx_waddr] <= wdata_q;
		tx_rdata_q <= tx_mem_q[tx_head_q];
	end

	always_ff @(posedge clk) begin
		if (rx_we) rx_mem_q[rx_waddr] <= rx_wdata;
		rx_rdata_q <= rx_mem_q[rx_head_q];
	end

	assign read_data      = rdata_q;
	assign access_error   = err_q;
	assign tx_valid       = txv_q;
	assign tx_word        = txw_q;
	assign interrupt_line = |(raw & imsc_q);

endmodule

// ===== sv/ssp_spi_controller_registers_unit.sv =====
// SSP/SPI register unit: bus register file with transmit and receive fifos. Each
// item (bus write, bus read or one frame exchange) passes through the cycle it
// is accepted, in which the fifo memories' registered read of both head words
// is made; the execute state, which updates registers, counts and fifo memories
// and loads the result register; and the result state, in which the result is
// offered until it is taken. The next item is accepted once the result has
// been taken, so the sequencer and the single registered read port of each fifo
// memory set the rate. There is no clearing pass after reset. Id registers are
// written through the configuration channel, which is always ready.
// top level; depends on sspcr_pkg, sspcr_ctrl, sspcr_datapath
module ssp_spi_controller_registers_unit
	import sspcr_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [11:0]         offset,
	input  logic [15:0]         write_data,
	input  logic [15:0]         rx_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         read_data,
	output logic                access_error,
	output logic                tx_valid,
	output logic [15:0]         tx_word,
	output logic                interrupt_line,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ID_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]     cfg_data
);

	sspcr_cmd_t cmd;

	assign cfg_ready = 1'b1;

	sspcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sspcr_datapath #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.command        (command),
		.offset         (offset),
		.write_data     (write_data),
		.rx_word        (rx_word),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.read_data      (read_data),
		.access_error   (access_error),
		.tx_valid       (tx_valid),
		.tx_word        (tx_word),
		.interrupt_line (interrupt_line)
	);

endmodule

// ===== sv/sspcr_checker.sv =====
// sspcr_checker: port-level assertions for the SSP/SPI register unit
// bound to ssp_spi_controller_registers_unit; depends on sspcr_pkg
module sspcr_checker
	import sspcr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] read_data,
	input logic        access_error,
	input logic        tx_valid,
	input logic [15:0] tx_word
);

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("item accepted while another in flight");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_word))
		else $error("stalled result changed");

	a_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_word == 16'd0)
		else $error("tx word without tx valid");

	// error only on writes, sends only on exchanges
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (access_error || tx_valid) |->
		read_data == 16'd0 && !(access_error && tx_valid))
		else $error("result fields from different commands");

endmodule

bind ssp_spi_controller_registers_unit sspcr_checker u_sspcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_data    (read_data),
	.access_error (access_error),
	.tx_valid     (tx_valid),
	.tx_word      (tx_word)
);
